/* rtl/i2c_mbx_pkg.sv */
// ----------------------------------------------------------------------------
// i2c_mbx_pkg
// Shared codes and types of the i2c target mailbox: item kinds, result
// status codes and the control word that goes along with a memory read.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_mbx_pkg;

    // item kinds carried on the input tuser
    localparam logic [2:0] MODE_WR_REQ    = 3'd0;
    localparam logic [2:0] MODE_RX_BYTE   = 3'd1;
    localparam logic [2:0] MODE_RD_REQ    = 3'd2;
    localparam logic [2:0] MODE_RD_DONE   = 3'd3;
    localparam logic [2:0] MODE_STOP      = 3'd4;
    localparam logic [2:0] MODE_HOST_POP  = 3'd5;
    localparam logic [2:0] MODE_HOST_LOAD = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TRUNC    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // byte answered when nothing is available
    localparam logic [7:0] NO_BYTE = 8'hFF;

    // smallest message length that raises notify
    localparam int MIN_MSG_BYTES = 2;

    // result control word, travels with the memory read of the same item
    typedef struct packed {
        logic       rx_rd;
        logic       tx_rd;
        logic [1:0] status;
        logic       notify;
    } res_meta_t;

endpackage

`default_nettype wire

/* rtl/i2c_mbx_ram.sv */
// ----------------------------------------------------------------------------
// i2c_mbx_ram
// Byte-wide simple dual-port memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mbx_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/i2c_mbx_ctrl.sv */
// ----------------------------------------------------------------------------
// i2c_mbx_ctrl
// Pointer and flag registers of the mailbox. Decodes each accepted item,
// issues the buffer write or read and forms the result control word.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mbx_ctrl #(
    parameter int BUFFER_BYTES = 256,
    parameter int AW           = 8,
    parameter int CW           = 9,
    parameter int LW           = 10
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic [2:0]             mode,
    input  wire logic                   last_byte,
    output logic                        rx_we,
    output logic      [AW-1:0]          rx_waddr,
    output logic                        rx_re,
    output logic      [AW-1:0]          rx_raddr,
    output logic                        tx_we,
    output logic      [AW-1:0]          tx_waddr,
    output logic                        tx_re,
    output logic      [AW-1:0]          tx_raddr,
    output i2c_mbx_pkg::res_meta_t      meta
);

    import i2c_mbx_pkg::*;

    localparam logic [CW-1:0] BUF_CNT  = CW'(BUFFER_BYTES);
    localparam logic [LW-1:0] BUF_LCNT = LW'(BUFFER_BYTES);
    localparam logic [LW-1:0] OVF_LCNT = LW'(BUFFER_BYTES + 1);
    localparam logic [CW-1:0] MIN_LEN  = CW'(MIN_MSG_BYTES);

    logic [CW-1:0] rx_len_reg, rx_len_next;
    logic [CW-1:0] pop_ptr_reg, pop_ptr_next;
    logic [CW-1:0] tx_len_reg, tx_len_next;
    logic [CW-1:0] tx_ptr_reg, tx_ptr_next;
    logic [LW-1:0] load_cnt_reg, load_cnt_next;
    logic          rd_phase_reg, rd_phase_next;
    logic          trunc_reg, trunc_next;
    logic          tx_avail;

    assign tx_avail = (tx_ptr_reg < tx_len_reg);

    assign rx_waddr = rx_len_reg[AW-1:0];
    assign rx_raddr = pop_ptr_reg[AW-1:0];
    assign tx_waddr = load_cnt_reg[AW-1:0];
    assign tx_raddr = tx_ptr_reg[AW-1:0];

    always_comb
    begin
        rx_len_next   = rx_len_reg;
        pop_ptr_next  = pop_ptr_reg;
        tx_len_next   = tx_len_reg;
        tx_ptr_next   = tx_ptr_reg;
        load_cnt_next = load_cnt_reg;
        rd_phase_next = rd_phase_reg;
        trunc_next    = trunc_reg;
        rx_we         = 1'b0;
        rx_re         = 1'b0;
        tx_we         = 1'b0;
        tx_re         = 1'b0;
        meta          = '{rx_rd: 1'b0, tx_rd: 1'b0, status: ST_OK, notify: 1'b0};

        unique case (mode)
            MODE_WR_REQ:
            begin
                rd_phase_next = 1'b0;
                trunc_next    = 1'b0;
                pop_ptr_next  = '0;
                rx_len_next   = '0;
            end
            MODE_RX_BYTE:
            begin
                if (rx_len_reg < BUF_CNT)
                begin
                    rx_we       = accept;
                    rx_len_next = rx_len_reg + 1'b1;
                end
                else
                begin
                    trunc_next  = 1'b1;
                    meta.status = ST_TRUNC;
                end
            end
            MODE_RD_REQ, MODE_RD_DONE:
            begin
                if (mode == MODE_RD_REQ)
                begin
                    rd_phase_next = 1'b1;
                end
                if (tx_avail)
                begin
                    tx_re       = accept;
                    meta.tx_rd  = 1'b1;
                    tx_ptr_next = tx_ptr_reg + 1'b1;
                end
            end
            MODE_STOP:
            begin
                if (!rd_phase_reg)
                begin
                    meta.notify = !trunc_reg && (rx_len_reg >= MIN_LEN);
                end
                else if (tx_ptr_reg == tx_len_reg)
                begin
                    tx_len_next = '0;
                    tx_ptr_next = '0;
                end
            end
            MODE_HOST_POP:
            begin
                if (pop_ptr_reg < rx_len_reg)
                begin
                    rx_re        = accept;
                    meta.rx_rd   = 1'b1;
                    pop_ptr_next = pop_ptr_reg + 1'b1;
                end
                else
                begin
                    meta.status = ST_EMPTY;
                end
            end
            MODE_HOST_LOAD:
            begin
                // first byte of a load hides the old message from the bus
                if (load_cnt_reg == '0)
                begin
                    tx_len_next = '0;
                    tx_ptr_next = '0;
                end
                if (load_cnt_reg < BUF_LCNT)
                begin
                    tx_we         = accept;
                    load_cnt_next = load_cnt_reg + 1'b1;
                end
                else
                begin
                    load_cnt_next = OVF_LCNT;
                    meta.status   = ST_OVERFLOW;
                end
                if (last_byte)
                begin
                    tx_len_next   = (load_cnt_next <= BUF_LCNT) ? load_cnt_next[CW-1:0] : '0;
                    tx_ptr_next   = '0;
                    load_cnt_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_len_reg   <= '0;
            pop_ptr_reg  <= '0;
            tx_len_reg   <= '0;
            tx_ptr_reg   <= '0;
            load_cnt_reg <= '0;
            rd_phase_reg <= 1'b0;
            trunc_reg    <= 1'b0;
        end
        else if (accept)
        begin
            rx_len_reg   <= rx_len_next;
            pop_ptr_reg  <= pop_ptr_next;
            tx_len_reg   <= tx_len_next;
            tx_ptr_reg   <= tx_ptr_next;
            load_cnt_reg <= load_cnt_next;
            rd_phase_reg <= rd_phase_next;
            trunc_reg    <= trunc_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/i2c_target_mailbox.sv */
// ----------------------------------------------------------------------------
// i2c_target_mailbox
// Bus-side i2c target mailbox: a receive buffer the bus fills and the host
// pops, and a transmit buffer the host loads and the bus reads back.
// ----------------------------------------------------------------------------
// Every input item gives exactly one result item. Bus events and host bytes
// come in on the s_ side, the kind of event on s_tuser; one item is taken
// per clock unless the result side stalls. A result passes the registered
// buffer read and then the output register. Throughput is one item per
// cycle while m_tready stays high, set by the single read and single write
// port of each buffer; each item touches at most one port of one buffer.
// Pointers and flags live in flip-flops and are updated at accept time, so
// a byte written by one item is visible to a read by the very next item.
// While the output register holds a result the pipeline still takes an item
// as long as the read stage is free. Buffer contents are not cleared by
// reset; only entries below the committed lengths are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_target_mailbox #(
    parameter int BUFFER_BYTES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input items
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_in
    input  wire logic [2:0] s_tuser,   // [2:0] mode
    input  wire logic       s_tlast,   // last_byte
    // result items
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] data_out
    output logic      [2:0] m_tuser    // [1:0] status, [2] notify
);

    import i2c_mbx_pkg::*;

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = $clog2(BUFFER_BYTES + 2);

    logic          accept;
    logic          s1_adv;

    // buffer ports
    logic          rx_we, rx_re, tx_we, tx_re;
    logic [AW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
    logic [7:0]    rx_q, tx_q;

    res_meta_t     meta;

    // read stage: control word waiting for the buffer data
    logic          s1_valid_reg;
    res_meta_t     s1_meta_reg;

    // output register
    logic          out_valid_reg;
    logic [7:0]    out_data_reg, out_data_next;
    logic [1:0]    out_status_reg;
    logic          out_notify_reg;

    // read stage moves on when the output register is free or being emptied
    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    i2c_mbx_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW),
        .CW           (CW),
        .LW           (LW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (s_tuser),
        .last_byte (s_tlast),
        .rx_we     (rx_we),
        .rx_waddr  (rx_waddr),
        .rx_re     (rx_re),
        .rx_raddr  (rx_raddr),
        .tx_we     (tx_we),
        .tx_waddr  (tx_waddr),
        .tx_re     (tx_re),
        .tx_raddr  (tx_raddr),
        .meta      (meta)
    );

    // receive buffer: bus writes, host pops
    i2c_mbx_ram #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (s_tdata),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_q)
    );

    // transmit buffer: host loads, bus reads
    i2c_mbx_ram #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (s_tdata),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_q)
    );

    // read data is held by the ram until the next accepted read, which can
    // only happen once the read stage has moved on
    always_comb
    begin
        if (s1_meta_reg.rx_rd)
        begin
            out_data_next = rx_q;
        end
        else if (s1_meta_reg.tx_rd)
        begin
            out_data_next = tx_q;
        end
        else
        begin
            out_data_next = NO_BYTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= accept;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= s1_meta_reg.status;
            out_notify_reg <= s1_meta_reg.notify;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_notify_reg, out_status_reg};

`ifndef ASSERT_OFF
    // notify only comes with a clean status
    a_notify_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == ST_OK))
        else $error("notify raised with a non-ok status");

    // an item never reads both buffers
    a_one_read: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_meta_reg.rx_rd && s1_meta_reg.tx_rd))
        else $error("item reads both buffers");

    // an accepted item lands in the read stage
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item lost before read stage");

    // a blocked read stage keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_meta_reg)))
        else $error("read stage changed while blocked");
`endif

endmodule

`default_nettype wire

/* tb/sv/i2c_target_mailbox_tb.sv */
// ----------------------------------------------------------------------------
// i2c_target_mailbox_tb
// Self-checking bench for the i2c target mailbox. A queue of bus events and
// host bytes feeds a bursty stream driver; a bit-accurate mailbox predictor
// works out the result of every accepted item and a monitor behind a
// stalling sink compares each result item field by field in order.
// ----------------------------------------------------------------------------

module i2c_target_mailbox_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import i2c_mbx_pkg::*;

    localparam int BUF = 256;

    // code the block has no meaning for
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    // rough stimulus size and settle time after the last result
    localparam int ITEM_TARGET  = 1650;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 100;

    // one input item plus a flag that makes the driver wait for an empty pipe
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data;
        logic       last;
        logic       hold;
    } bus_item_t;

    // one result item
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       notify;
    } mbx_result_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic [2:0] s_tuser  = 3'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;

    i2c_target_mailbox #(.BUFFER_BYTES(BUF)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // mailbox predictor state
    // ------------------------------------------------------------------------
    logic [7:0] rx_mem [BUF];
    logic [7:0] tx_mem [BUF];
    logic [8:0] rx_len      = '0;
    logic [8:0] rx_pop_ptr  = '0;
    logic [8:0] tx_len      = '0;
    logic [8:0] tx_ptr      = '0;
    logic [9:0] load_cnt    = '0;
    logic       read_phase  = 1'b0;
    logic       rx_trunc    = 1'b0;

    bus_item_t   pending_items[$];
    mbx_result_t expected_results[$];

    int n_queued    = 0;    // queued items the block acts on
    int n_accepted  = 0;    // written by the driver only
    int n_results   = 0;    // written by the monitor only
    int mismatches  = 0;

    // next reply byte for a bus read, 0xff once the reply is used up
    function automatic logic [7:0] next_reply_byte();
        logic [7:0] b;
        b = NO_BYTE;
        if (tx_ptr < tx_len && tx_ptr < BUF) begin
            b = tx_mem[tx_ptr];
            tx_ptr++;
        end
        return b;
    endfunction

    // advance the mailbox by one item and return the result it gives
    function automatic mbx_result_t mailbox_step(bus_item_t it);
        mbx_result_t r;
        r.data   = NO_BYTE;
        r.status = ST_OK;
        r.notify = 1'b0;
        case (it.mode)
            MODE_WR_REQ:
            begin
                read_phase = 1'b0;
                rx_trunc   = 1'b0;
                rx_pop_ptr = '0;
                rx_len     = '0;
            end
            MODE_RX_BYTE:
            begin
                // bytes past a full buffer are dropped and flag truncation
                if (rx_len < BUF) begin
                    rx_mem[rx_len] = it.data;
                    rx_len++;
                end else begin
                    rx_trunc = 1'b1;
                    r.status = ST_TRUNC;
                end
            end
            MODE_RD_REQ:
            begin
                read_phase = 1'b1;
                r.data     = next_reply_byte();
            end
            MODE_RD_DONE:
            begin
                r.data = next_reply_byte();
            end
            MODE_STOP:
            begin
                if (!read_phase) begin
                    if (!rx_trunc && rx_len >= MIN_MSG_BYTES)
                        r.notify = 1'b1;
                end else if (tx_ptr == tx_len) begin
                    // reply fully sent, free the transmit buffer
                    tx_len = '0;
                    tx_ptr = '0;
                end
            end
            MODE_HOST_POP:
            begin
                if (rx_pop_ptr < rx_len && rx_pop_ptr < BUF) begin
                    r.data = rx_mem[rx_pop_ptr];
                    rx_pop_ptr++;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            MODE_HOST_LOAD:
            begin
                // first byte of a load drops the old reply
                if (load_cnt == 0) begin
                    tx_len = '0;
                    tx_ptr = '0;
                end
                if (load_cnt < BUF) begin
                    tx_mem[load_cnt] = it.data;
                    load_cnt++;
                end else begin
                    load_cnt = BUF + 1;
                    r.status = ST_OVERFLOW;
                end
                // commit: an oversized reply leaves nothing to read
                if (it.last) begin
                    tx_len   = (load_cnt <= BUF) ? load_cnt[8:0] : '0;
                    tx_ptr   = '0;
                    load_cnt = '0;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        // keep the log short when everything goes wrong
        if (mismatches <= MAX_PRINTS)
            $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic add_item(input logic [2:0] mode, input logic [7:0] data,
                            input logic last, input logic hold);
        bus_item_t it;
        it.mode = mode;
        it.data = data;
        it.last = last;
        it.hold = hold;
        pending_items.push_back(it);
        if (mode != MODE_UNUSED)
            n_queued++;
    endtask

    // ------------------------------------------------------------------------
    // stream driver: bursts of items with random gaps between them
    // ------------------------------------------------------------------------
    bus_item_t cur_item   = '0;
    int        burst_left = 1;
    int        gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : item_driver
        logic        took;
        logic        valid_next;
        mbx_result_t res;
        if (!rst_n) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'h00;
            s_tuser    <= 3'd0;
            s_tlast    <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            took = s_tvalid && s_tready;
            if (took) begin
                res = mailbox_step(cur_item);
                expected_results.push_back(res);
                n_accepted++;
            end
            // an item not yet taken stays on the bus unchanged
            if (!s_tvalid || took) begin
                valid_next = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].hold && n_accepted != n_results)) begin
                    cur_item   = pending_items.pop_front();
                    valid_next = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // mostly short bursts, now and then a long gapless run
                        if ($urandom_range(0, 9) == 0) begin
                            burst_left = $urandom_range(100, 300);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 20);
                            gap_left   = ($urandom_range(0, 7) == 0) ?
                                         $urandom_range(8, 25) : $urandom_range(0, 4);
                        end
                    end
                end
                s_tvalid <= valid_next;
                s_tdata  <= cur_item.data;
                s_tuser  <= cur_item.mode;
                s_tlast  <= cur_item.last;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result sink: ready follows a style that changes every so often
    // ------------------------------------------------------------------------
    int       sink_style = 0;
    int       style_left = 0;
    int       stall_left = 0;
    bit [1:0] sink_phase = '0;

    always @(posedge clk or negedge rst_n)
    begin : sink_pacer
        logic rdy;
        if (!rst_n) begin
            m_tready   <= 1'b0;
            style_left = 0;
            stall_left = 0;
        end else begin
            if (style_left == 0) begin
                sink_style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 200);
            end else begin
                style_left--;
            end
            sink_phase++;
            case (sink_style)
                0: rdy = 1'b1;                      // never stalls
                1: rdy = $urandom_range(0, 1);      // coin flip
                2: rdy = (sink_phase == 2'd0);      // ready only when the phase counter is zero
                default:
                begin
                    // occasional long stalls
                    if (stall_left > 0) begin
                        stall_left--;
                        rdy = 1'b0;
                    end else begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            stall_left = $urandom_range(5, 20);
                    end
                end
            endcase
            m_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        mbx_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            n_results <= n_results + 1;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result data", m_tdata, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch("data_out", m_tdata, want.data);
                if (m_tuser[1:0] !== want.status)
                    report_mismatch("status", m_tuser[1:0], want.status);
                if (m_tuser[2] !== want.notify)
                    report_mismatch("notify", m_tuser[2], want.notify);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int seq;
        int kind;
        int n;
        int k;
        logic big;
        logic hold;

        // directed: empty buffers, field extremes, every mode
        add_item(MODE_HOST_POP,  8'h00, 1'b0, 1'b0);   // pop with nothing received
        add_item(MODE_RD_REQ,    8'hFF, 1'b1, 1'b0);   // read before any reply
        add_item(MODE_RD_DONE,   8'h00, 1'b0, 1'b0);
        add_item(MODE_STOP,      8'h00, 1'b0, 1'b0);   // read stop on empty reply
        add_item(MODE_WR_REQ,    8'hFF, 1'b1, 1'b0);
        add_item(MODE_RX_BYTE,   8'h00, 1'b0, 1'b0);
        add_item(MODE_RX_BYTE,   8'hFF, 1'b1, 1'b0);
        add_item(MODE_STOP,      8'h00, 1'b0, 1'b0);   // two bytes, notify
        add_item(MODE_HOST_POP,  8'h00, 1'b0, 1'b0);
        add_item(MODE_HOST_POP,  8'h00, 1'b0, 1'b0);   // real 0xff byte, status ok
        add_item(MODE_HOST_POP,  8'h00, 1'b0, 1'b0);   // empty again
        add_item(MODE_WR_REQ,    8'h00, 1'b0, 1'b0);
        add_item(MODE_RX_BYTE,   8'h80, 1'b1, 1'b0);
        add_item(MODE_STOP,      8'h00, 1'b0, 1'b0);   // one byte, no notify
        add_item(MODE_HOST_LOAD, 8'h00, 1'b0, 1'b0);   // load start
        add_item(MODE_RD_REQ,    8'h00, 1'b0, 1'b0);   // uncommitted load reads 0xff
        add_item(MODE_HOST_LOAD, 8'hFF, 1'b0, 1'b0);
        add_item(MODE_HOST_LOAD, 8'h01, 1'b1, 1'b0);   // commit three bytes
        add_item(MODE_RD_REQ,    8'h00, 1'b0, 1'b0);
        add_item(MODE_STOP,      8'h00, 1'b0, 1'b0);   // reply not done, kept
        add_item(MODE_RD_REQ,    8'h00, 1'b0, 1'b0);
        add_item(MODE_RD_DONE,   8'h00, 1'b0, 1'b0);
        add_item(MODE_RD_DONE,   8'h00, 1'b0, 1'b0);   // past the end
        add_item(MODE_STOP,      8'h00, 1'b0, 1'b0);   // reply done, freed
        add_item(MODE_UNUSED,    8'hFF, 1'b1, 1'b0);

        // random sequences; the first two overfill receive and transmit buffers
        seq = 0;
        while (n_queued < ITEM_TARGET) begin
            hold = (seq == 0) || ($urandom_range(0, 49) == 0);
            big  = (seq < 2) || ($urandom_range(0, 39) == 0);
            n    = big ? $urandom_range(250, 260) : $urandom_range(0, 10);
            if (seq < 2)
                n = $urandom_range(257, 260);
            kind = (seq == 0) ? 0 : (seq == 1) ? 2 : $urandom_range(0, 8);
            case (kind)
                0, 1:
                begin
                    // bus write message, mostly followed by host pops
                    add_item(MODE_WR_REQ, $urandom_range(0, 255), $urandom_range(0, 1), hold);
                    for (int i = 0; i < n; i++)
                        add_item(MODE_RX_BYTE, $urandom_range(0, 255),
                                 $urandom_range(0, 1), 1'b0);
                    if ($urandom_range(0, 9) != 0)
                        add_item(MODE_STOP, $urandom_range(0, 255), $urandom_range(0, 1), 1'b0);
                    if ($urandom_range(0, 9) < 7) begin
                        k = (n > BUF ? BUF : n) + $urandom_range(0, 2);
                        for (int i = 0; i < k; i++)
                            add_item(MODE_HOST_POP, $urandom_range(0, 255),
                                     $urandom_range(0, 1), 1'b0);
                    end
                end
                2, 3:
                begin
                    // host reply load, now and then left uncommitted
                    if (n == 0)
                        n = 1;
                    for (int i = 0; i < n; i++)
                        add_item(MODE_HOST_LOAD, $urandom_range(0, 255),
                                 (i == n - 1) && ($urandom_range(0, 9) != 0),
                                 (i == 0) && hold);
                end
                4, 5:
                begin
                    // bus read of the reply
                    add_item(MODE_RD_REQ, $urandom_range(0, 255), $urandom_range(0, 1), hold);
                    k = $urandom_range(0, n + 1);
                    for (int i = 0; i < k; i++)
                        add_item(MODE_RD_DONE, $urandom_range(0, 255),
                                 $urandom_range(0, 1), 1'b0);
                    if ($urandom_range(0, 9) != 0)
                        add_item(MODE_STOP, $urandom_range(0, 255), $urandom_range(0, 1), 1'b0);
                end
                6:
                begin
                    k = $urandom_range(1, 4);
                    for (int i = 0; i < k; i++)
                        add_item(MODE_HOST_POP, $urandom_range(0, 255),
                                 $urandom_range(0, 1), (i == 0) && hold);
                end
                default:
                begin
                    // noise: any mode, any content
                    k = $urandom_range(1, 6);
                    for (int i = 0; i < k; i++)
                        add_item($urandom_range(0, 7), $urandom_range(0, 255),
                                 $urandom_range(0, 1), (i == 0) && hold);
                end
            endcase
            seq++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // everything sent and every prediction matched by a result
        @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("missing result count", 0, expected_results.size());

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin : watchdog
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
